[hw/rtl/fufr_pkg.sv]
// Package for the firmware update frame receiver: payload types, frame codes,
// result kinds, register indexes and the CRC-8 step function.
// No dependencies.
`default_nettype none

package fufr_pkg;

    // Defaults for the top-level parameters
    localparam int PAYLOAD_DEPTH_DEF    = 256;
    localparam int SECTORS_PER_BANK_DEF = 12;

    // Frame bytes
    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] CRC_POLY  = 8'h31;
    localparam logic [7:0] OP_START  = 8'hF0;
    localparam logic [7:0] OP_CHUNK  = 8'hF1;
    localparam logic [7:0] OP_END    = 8'hF2;
    localparam logic [7:0] RSP_ACK   = 8'h21;
    localparam logic [7:0] RSP_NACK  = 8'h22;

    localparam logic [31:0] DEFAULT_BASE = 32'h0810_0000;

    // Input request types
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_ERASE  = 3'd1;
    localparam logic [2:0] KIND_ACK    = 3'd2;
    localparam logic [2:0] KIND_NACK   = 3'd3;
    localparam logic [2:0] KIND_SWITCH = 3'd4;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_BANK = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_BASE  = 1'd1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [31:0] flash_address;
        logic [31:0] flash_data;
        logic [4:0]  erase_sector;
        logic [7:0]  resp_crc;
        logic        last;
    } t_out;

    // Completed frame handed from the deframer to the action sequencer
    typedef struct packed {
        logic       good;
        logic [7:0] cmd;
        logic [7:0] len;
    } t_frame;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int j = 0; j < 8; j++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [7:0] ACK_CRC  = crc8_feed(crc8_feed(8'h00, RSP_ACK), 8'h00);
    localparam logic [7:0] NACK_CRC = crc8_feed(crc8_feed(8'h00, RSP_NACK), 8'h00);

endpackage

`default_nettype wire

[hw/rtl/fufr_payload_ram.sv]
// Payload store: word-wide synchronous RAM with a byte-lane write port and a
// registered read port. Depends on nothing.
`default_nettype none

module fufr_payload_ram #(
    parameter int AW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [1:0]    i_wlane,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr][8*i_wlane +: 8] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/fufr_deframer.sv]
// Byte deframer: header hunt, command, length, payload capture into the
// payload RAM and running CRC-8. Depends on fufr_pkg.
`default_nettype none

module fufr_deframer #(
    parameter int PAYLOAD_DEPTH = 256,
    parameter int AW            = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire fufr_pkg::t_in   i_in_data,
    input  wire logic            i_busy,
    output logic                 o_start,
    output fufr_pkg::t_frame     o_frame,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [1:0]           o_wlane,
    output logic [7:0]           o_wdata
);
    import fufr_pkg::*;

    typedef enum logic [2:0] {D_IDLE, D_CMD, D_LEN, D_DATA, D_CRC} t_dstate;

    t_dstate    r_state;
    logic [7:0] r_cmd;
    logic [7:0] r_len;
    logic [7:0] r_count;
    logic [7:0] r_crc;
    logic       r_start;
    t_frame     r_frame;

    logic       accept;
    logic [7:0] b;
    logic [7:0] crc_next;
    logic [7:0] n_count;

    assign o_in_ready = !i_busy && !r_start;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_in_data.rx_byte;
    assign crc_next   = crc8_feed(r_crc, b);
    assign n_count    = r_count + 8'd1;

    // Store payload bytes that fit
    assign o_we    = accept && (i_in_data.req_type == REQ_BYTE) && (r_state == D_DATA)
                     && ({1'b0, r_count} < 9'(PAYLOAD_DEPTH));
    assign o_waddr = r_count[AW+1:2];
    assign o_wlane = r_count[1:0];
    assign o_wdata = b;

    assign o_start = r_start;
    assign o_frame = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cmd   <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_crc   <= '0;
            r_start <= 1'b0;
            r_frame <= '0;
        end else begin
            r_start <= 1'b0;
            if (accept) begin
                if (i_in_data.req_type == REQ_TIMEOUT) begin
                    r_state <= D_IDLE;
                end else begin
                    case (r_state)
                        D_CMD: begin
                            r_cmd   <= b;
                            r_crc   <= crc8_feed(8'h00, b);
                            r_state <= D_LEN;
                        end
                        D_LEN: begin
                            r_len   <= b;
                            r_crc   <= crc_next;
                            r_count <= '0;
                            r_state <= (b == 8'h00) ? D_CRC : D_DATA;
                        end
                        D_DATA: begin
                            r_crc   <= crc_next;
                            r_count <= n_count;
                            if (n_count == r_len) begin
                                r_state <= D_CRC;
                            end
                        end
                        D_CRC: begin
                            r_state       <= D_IDLE;
                            r_start       <= 1'b1;
                            r_frame.good  <= (b == r_crc);
                            r_frame.cmd   <= r_cmd;
                            r_frame.len   <= r_len;
                        end
                        default: begin
                            r_state <= (b == SYNC_BYTE) ? D_CMD : D_IDLE;
                        end
                    endcase
                end
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/fufr_action.sv]
// Action sequencer: turns a completed frame into results, reading the payload
// RAM word by word for chunk writes; holds the expected offset and the result
// register. Depends on fufr_pkg.
`default_nettype none

module fufr_action #(
    parameter int PAYLOAD_DEPTH    = 256,
    parameter int SECTORS_PER_BANK = 12,
    parameter int AW               = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire fufr_pkg::t_frame i_frame,
    input  wire logic             i_active_bank,
    input  wire logic [31:0]      i_write_base,
    output logic                  o_busy,
    output logic                  o_re,
    output logic [AW-1:0]         o_raddr,
    input  wire logic [31:0]      i_rdata,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output fufr_pkg::t_out        o_out_data
);
    import fufr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ERASE, S_ACK, S_NACK, S_SWITCH, S_OFFSET, S_WORD
    } t_astate;

    t_astate     r_state;
    t_out        r_out;
    logic        r_out_valid;
    logic [31:0] r_exp;
    logic [31:0] r_addr;
    logic [5:0]  r_word;
    logic [7:0]  r_rem;
    logic [7:0]  r_len;

    logic        out_free;
    logic [7:0]  dlen;
    logic [5:0]  rd_word;
    logic [31:0] word_data;

    assign out_free    = !r_out_valid || i_out_ready;
    assign dlen        = r_len - 8'd4;
    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_raddr     = rd_word[AW-1:0];

    // Read issue: offset word on a chunk, then one data word per result
    always_comb begin
        o_re    = 1'b0;
        rd_word = r_word;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_frame.good && (i_frame.cmd == OP_CHUNK)
                        && (i_frame.len >= 8'd4)) begin
                    o_re    = 1'b1;
                    rd_word = 6'd0;
                end
            end
            S_OFFSET: begin
                if ((i_rdata == r_exp) && (dlen != 8'd0)) begin
                    o_re    = 1'b1;
                    rd_word = 6'd1;
                end
            end
            S_WORD: begin
                if (out_free && (r_rem > 8'd4)) begin
                    o_re    = 1'b1;
                    rd_word = r_word + 6'd1;
                end
            end
            default: begin
                o_re = 1'b0;
            end
        endcase
    end

    // Pad bytes past the data, and past the stored depth, with 0xFF
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if ((8'(k) < r_rem)
                    && (({1'b0, r_word, 2'b00} + 9'(k)) < 9'(PAYLOAD_DEPTH))) begin
                word_data[8*k +: 8] = i_rdata[8*k +: 8];
            end else begin
                word_data[8*k +: 8] = 8'hFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_exp       <= '0;
            r_word      <= '0;
            r_rem       <= '0;
            r_len       <= '0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_len <= i_frame.len;
                        if (!i_frame.good) begin
                            r_state <= S_NACK;
                        end else if (i_frame.cmd == OP_START) begin
                            r_state <= S_ERASE;
                        end else if (i_frame.cmd == OP_CHUNK) begin
                            r_state <= (i_frame.len < 8'd4) ? S_NACK : S_OFFSET;
                        end else if (i_frame.cmd == OP_END) begin
                            r_state <= S_SWITCH;
                        end
                    end
                end
                S_OFFSET: begin
                    if (i_rdata != r_exp) begin
                        r_state <= S_NACK;
                    end else begin
                        r_exp   <= r_exp + 32'(dlen);
                        r_addr  <= i_write_base + i_rdata;
                        r_rem   <= dlen;
                        r_word  <= 6'd1;
                        r_state <= (dlen == 8'd0) ? S_ACK : S_WORD;
                    end
                end
                S_WORD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{KIND_WRITE, r_addr, word_data, 5'd0, 8'h00, 1'b0};
                        r_addr      <= r_addr + 32'd4;
                        r_word      <= rd_word;
                        if (r_rem > 8'd4) begin
                            r_rem <= r_rem - 8'd4;
                        end else begin
                            r_rem   <= 8'd0;
                            r_state <= S_ACK;
                        end
                    end
                end
                S_ERASE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{KIND_ERASE, 32'd0, 32'd0,
                                         i_active_bank ? 5'd0 : 5'(SECTORS_PER_BANK),
                                         8'h00, 1'b0};
                        r_exp       <= '0;
                        r_state     <= S_ACK;
                    end
                end
                S_ACK: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{KIND_ACK, 32'd0, 32'd0, 5'd0, ACK_CRC, 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                S_NACK: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{KIND_NACK, 32'd0, 32'd0, 5'd0, NACK_CRC, 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                S_SWITCH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{KIND_SWITCH, 32'd0, 32'd0, 5'd0, 8'h00, 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("frame handed over while sequencer busy");

    a_word_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.out_kind == KIND_WRITE)) |-> !r_out.last)
        else $error("word write flagged as last result");

    a_word_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WORD) |-> (r_rem != 8'd0))
        else $error("word state entered with no data left");

    a_word_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WORD) && !$past(r_state == S_WORD)) |-> $past(o_re))
        else $error("word state entered without a RAM read");
`endif

endmodule

`default_nettype wire

[hw/rtl/firmware_update_frame_receiver.sv]
// Top level of the firmware update frame receiver: configuration registers,
// payload RAM, deframer and action sequencer. Depends on fufr_pkg and all
// fufr_* modules.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+-------------------------
//   in      | sink      | i_in_valid / o_in_ready    | i_in_data  (t_in)
//   out     | source    | o_out_valid / i_out_ready  | o_out_data (t_out)
//   cfg     | sink      | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// The deframer takes header, command, length, payload and timeout transactions
// while the sequencer is idle. The CRC byte hands the frame to the action
// sequencer; input is held off until it has finished. Start gives two results
// and End or a NACK one, at one per cycle while the output is not stalled. A
// good chunk reads and checks the offset word; if it matches, it gives a word
// write per data word and an ACK, paced by the RAM's single read port.
// Reset (synchronous, active low) clears the control state; the payload RAM is
// not cleared since only bytes of the current frame are ever read.
// A stalled output holds its result register and, behind it, the sequencer.
`default_nettype none

module firmware_update_frame_receiver #(
    parameter int PAYLOAD_DEPTH    = fufr_pkg::PAYLOAD_DEPTH_DEF,
    parameter int SECTORS_PER_BANK = fufr_pkg::SECTORS_PER_BANK_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire fufr_pkg::t_in                      i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output fufr_pkg::t_out                          o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [fufr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [31:0]                        i_cfg_data
);
    import fufr_pkg::*;

    // Payload words: offset in word 0, data from word 1 on
    localparam int WORDS = (PAYLOAD_DEPTH + 3) / 4;
    localparam int AW    = $clog2(WORDS);

    logic        r_active_bank;
    logic [31:0] r_write_base;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [1:0]    ram_wlane;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic   act_busy;
    logic   frame_start;
    t_frame frame;

    // Configuration registers: the user must write them only while the block is idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bank <= 1'b0;
            r_write_base  <= DEFAULT_BASE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE_BANK: r_active_bank <= i_cfg_data[0];
                CFG_WRITE_BASE:  r_write_base  <= i_cfg_data;
                default:         r_active_bank <= r_active_bank;
            endcase
        end
    end

    fufr_payload_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wlane (ram_wlane),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fufr_deframer #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .AW            (AW)
    ) u_deframer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_busy     (act_busy),
        .o_start    (frame_start),
        .o_frame    (frame),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wlane    (ram_wlane),
        .o_wdata    (ram_wdata)
    );

    fufr_action #(
        .PAYLOAD_DEPTH    (PAYLOAD_DEPTH),
        .SECTORS_PER_BANK (SECTORS_PER_BANK),
        .AW               (AW)
    ) u_action (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (frame_start),
        .i_frame       (frame),
        .i_active_bank (r_active_bank),
        .i_write_base  (r_write_base),
        .o_busy        (act_busy),
        .o_re          (ram_re),
        .o_raddr       (ram_raddr),
        .i_rdata       (ram_rdata),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_ram_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !ram_re)
        else $error("payload RAM written and read in the same cycle");

    a_no_input_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frame_start || act_busy) |-> !o_in_ready)
        else $error("input taken while a frame is being acted on");

    a_write_only_idle_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !act_busy)
        else $error("payload stored while sequencer reads the RAM");
`endif

endmodule

`default_nettype wire
